// ===== src/bst_pkg.sv =====
// Package for the bencode stream tokenizer: beat types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package bst_pkg;

  localparam int unsigned DepthDefault  = 32;
  localparam int unsigned LenWidthDefault = 32;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_DOPEN = 3'd1, EV_LOPEN = 3'd2, EV_CLOSE = 3'd3,
    EV_INT = 3'd4, EV_SSTART = 3'd5, EV_SBYTE = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    ERR_OK = 4'd0, ERR_EARLY_END = 4'd1, ERR_WRONG_CHAR = 4'd2,
    ERR_BAD_START = 4'd3, ERR_KEY_NOT_STR = 4'd4, ERR_NO_DIGITS = 4'd5,
    ERR_STR_CUT = 4'd6, ERR_TOO_DEEP = 4'd7, ERR_OVERFLOW = 4'd8
  } err_e;

  typedef enum logic [1:0] {
    LV_NONE = 2'd0, LV_LIST = 2'd1, LV_DKEY = 2'd2, LV_DVAL = 2'd3
  } level_e;

  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [63:0] value;
    logic        is_key;
    logic        doc_done;
    logic [3:0]  error;
  } out_beat_t;

endpackage

// ===== src/bst_level_mem.sv =====
// Level stack storage for the bencode tokenizer: one write port, one registered
// read port with write-through. Depends on bst_pkg.
`timescale 1ns / 1ps
module bst_level_mem import bst_pkg::*; #(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [1:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [1:0]               rdata_o
);
  logic [1:0] mem_q [Depth];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // same-edge write to the read address is passed through
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/bencode_stream_tokenizer.sv =====
// Top level of the bencode stream tokenizer: grammar check and event output.
// Depends on bst_pkg and bst_level_mem.
`timescale 1ns / 1ps
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+--------------------------
//  in      | input     | in_beat_t  | in_valid_i / in_stall_o
//  out     | output    | out_beat_t | out_valid_o / out_stall_i
//
// Every input beat yields exactly one output beat; one beat per cycle unless
// the output stalls. The result is registered: the parse state and the
// result register update in the same edge. The top-of-stack entry is held
// in a register (top_q) so only a push needs the level memory; the memory
// read is registered and addressed one below the next top, so the entry
// under the top is ready when a pop comes. in_stall_o follows out_stall_i
// only while the output register is full, so a beat is taken even while a
// result waits if it is being drained. Reset clears the parse state; stack
// contents are not cleared (an entry is always written before it is read).
module bencode_stream_tokenizer import bst_pkg::*; #(
  parameter int unsigned DEPTH     = DepthDefault,
  parameter int unsigned LEN_WIDTH = LenWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  // largest string length and its split for the per-digit overflow check
  localparam logic [63:0] LenMax      = (64'd1 << LEN_WIDTH) - 64'd1;
  localparam logic [63:0] LenMaxDiv10 = LenMax / 64'd10;
  localparam logic [63:0] LenMaxMod10 = LenMax % 64'd10;

  typedef enum logic [3:0] {
    M_VALUE, M_KEY, M_INT_START, M_INT_NEG, M_INT_DIG,
    M_LEN_VAL, M_LEN_KEY, M_STR_VAL, M_STR_KEY, M_DONE
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic [1:0]     top_q, top_d;     // entry at lvl_q-1
  logic [63:0]    acc_q, acc_d;
  logic           neg_q, neg_d;
  logic [LEN_WIDTH-1:0] cnt_q, cnt_d;
  err_e           err_q, err_d;
  logic           done_q, done_d;
  out_beat_t      res_q, res_d;
  logic           vld_q;

  logic           take;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [LW-1:0]  lvl_nxt;
  logic [1:0]     below;

  assign in_stall_o  = vld_q & out_stall_i;
  assign take        = in_valid_i & ~in_stall_o;
  assign out_valid_o = vld_q;
  assign out_data_o  = res_q;

  // Entry below the next top, for pops (used only when lvl_q >= 2).
  assign lvl_nxt = take ? lvl_d : lvl_q;
  assign raddr = (lvl_nxt >= LW'(2)) ? AW'(lvl_nxt - LW'(2)) : '0;

  bst_level_mem #(.Depth(DEPTH)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(top_q),
    .raddr_i(raddr), .rdata_o(below)
  );

  // Combinational byte step.
  always_comb begin
    logic [7:0]  b;
    logic [3:0]  dg;
    logic        isdig;
    mode_e       m;
    logic [LW-1:0] l;
    logic [1:0]  t;
    logic [63:0] a;
    logic        n;
    logic [LEN_WIDTH-1:0] c;
    err_e        e;
    logic        dn;
    logic        cmp, cmp_key;
    logic [63:0] lim, a10;
    logic [2:0]  ev;
    logic [63:0] val;
    logic        key;

    b = in_data_i.data_byte;
    dg = b[3:0] - ChZero[3:0];
    isdig = (b >= ChZero) && (b <= ChZero + 8'd9);
    if (in_data_i.restart) begin
      m = M_VALUE; l = '0; t = top_q; a = '0; n = 1'b0; c = '0;
      e = ERR_OK; dn = 1'b0;
    end else begin
      m = mode_q; l = lvl_q; t = top_q; a = acc_q; n = neg_q; c = cnt_q;
      e = err_q; dn = done_q;
    end
    ev = EV_NONE; val = '0; key = 1'b0; cmp = 1'b0; cmp_key = 1'b0;
    we = 1'b0; waddr = '0;
    a10 = {a[60:0], 3'b000} + {a[62:0], 1'b0} + 64'(dg);
    lim = n ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;

    if (e == ERR_OK && m != M_DONE) begin
      unique case (m)
        M_VALUE, M_KEY: begin
          if (b == ChE && l != '0 && (m == M_KEY || t == LV_LIST)) begin
            ev = EV_CLOSE;
            l = l - LW'(1);
            t = (l != '0) ? below : t;
            cmp = 1'b1;
          end else if (isdig) begin
            a = 64'(dg);
            m = (m == M_KEY) ? M_LEN_KEY : M_LEN_VAL;
          end else if (m == M_KEY) begin
            e = ERR_KEY_NOT_STR;
          end else if (b == ChD || b == ChL) begin
            if (l >= LW'(DEPTH)) begin
              e = ERR_TOO_DEEP;
            end else begin
              if (l != '0) begin
                we = 1'b1; waddr = AW'(l - LW'(1));
              end
              t = (b == ChD) ? LV_DKEY : LV_LIST;
              l = l + LW'(1);
              m = (b == ChD) ? M_KEY : M_VALUE;
              ev = (b == ChD) ? EV_DOPEN : EV_LOPEN;
            end
          end else if (b == ChI) begin
            a = '0; n = 1'b0; m = M_INT_START;
          end else begin
            e = ERR_BAD_START;
          end
        end
        M_INT_START, M_INT_NEG, M_INT_DIG: begin
          if (isdig) begin
            // acc*10+d > lim  <=> acc > (lim-d)/10
            if (a > 64'd922337203685477580 ||
                (a == 64'd922337203685477580 && 64'(dg) > lim - 64'd9223372036854775800))
              e = ERR_OVERFLOW;
            else begin
              a = a10; m = M_INT_DIG;
            end
          end else if (m == M_INT_START && b == ChMinus) begin
            n = 1'b1; m = M_INT_NEG;
          end else if (m != M_INT_DIG) begin
            e = ERR_NO_DIGITS;
          end else if (b == ChE) begin
            ev = EV_INT; val = n ? (64'd0 - a) : a; cmp = 1'b1;
          end else begin
            e = ERR_WRONG_CHAR;
          end
        end
        M_LEN_VAL, M_LEN_KEY: begin
          if (isdig) begin
            if (a > LenMaxDiv10 || (a == LenMaxDiv10 && 64'(dg) > LenMaxMod10))
              e = ERR_OVERFLOW;
            else
              a = a10;
          end else if (b == ChColon) begin
            ev = EV_SSTART; val = a; key = (m == M_LEN_KEY);
            c = LEN_WIDTH'(a);
            if (a == '0) begin
              cmp = 1'b1; cmp_key = key;
            end else begin
              m = key ? M_STR_KEY : M_STR_VAL;
            end
          end else begin
            e = ERR_WRONG_CHAR;
          end
        end
        default: begin
          ev = EV_SBYTE; val = 64'(b); key = (m == M_STR_KEY);
          c = c - LEN_WIDTH'(1);
          if (c == '0) begin
            cmp = 1'b1; cmp_key = key;
          end
        end
      endcase
      if (cmp) begin
        if (l == '0) begin
          dn = 1'b1; m = M_DONE;
        end else if (t == LV_LIST) begin
          m = M_VALUE;
        end else if (cmp_key) begin
          t = LV_DVAL; m = M_VALUE;
        end else begin
          t = LV_DKEY; m = M_KEY;
        end
      end
      if (e != ERR_OK) begin
        ev = EV_NONE; val = '0; key = 1'b0; we = 1'b0;
      end else if (in_data_i.last_byte && !dn) begin
        e = ((m == M_STR_VAL || m == M_STR_KEY) && c != '0) ? ERR_STR_CUT
                                                              : ERR_EARLY_END;
      end
    end

    mode_d = m; lvl_d = l; top_d = t; acc_d = a; neg_d = n; cnt_d = c;
    err_d = e; done_d = dn;
    res_d.event_res = ev; res_d.value = val; res_d.is_key = key;
    res_d.doc_done = dn; res_d.error = e;
    we = we & take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_VALUE; lvl_q <= '0; acc_q <= '0; neg_q <= 1'b0;
      cnt_q <= '0; err_q <= ERR_OK; done_q <= 1'b0; vld_q <= 1'b0;
      top_q <= LV_NONE;
    end else begin
      if (take) begin
        mode_q <= mode_d; lvl_q <= lvl_d; top_q <= top_d; acc_q <= acc_d;
        neg_q <= neg_d; cnt_q <= cnt_d; err_q <= err_d; done_q <= done_d;
      end
      if (take) vld_q <= 1'b1;
      else if (!out_stall_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LW'(DEPTH)) else $error("stack level beyond depth");
  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.event_res == EV_NONE) |-> (res_q.value == '0 && !res_q.is_key))
    else $error("payload on a beat without event");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && out_stall_i) |=> (vld_q && $stable(res_q)))
    else $error("stalled result lost");
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for bencode_stream_tokenizer: random bencoded documents,
// directed grammar faults, one expected beat per input beat. Depends on bst_pkg.
`timescale 1ns / 1ps
module tb_top;
  import bst_pkg::*;

  localparam int unsigned Depth    = DepthDefault;
  localparam int unsigned LenWidth = LenWidthDefault;
  localparam int unsigned WatchdogLimit = 20000;

  // parse modes of the predictor
  typedef enum logic [3:0] {
    PM_VALUE, PM_KEY, PM_INT_START, PM_INT_NEG, PM_INT_DIG,
    PM_LEN_VAL, PM_LEN_KEY, PM_STR_VAL, PM_STR_KEY, PM_DONE
  } pmode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  bencode_stream_tokenizer #(.DEPTH(Depth), .LEN_WIDTH(LenWidth)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  // predictor state
  pmode_e      p_mode;
  level_e      p_stack [Depth];
  int unsigned p_level;
  logic [63:0] p_accum;
  logic        p_neg;
  logic [63:0] p_count;
  err_e        p_err;
  logic        p_done;

  in_beat_t  pending_beats [$];
  out_beat_t expected_beats [$];
  int unsigned fail_count = 0;
  int unsigned beats_in = 0, beats_out = 0;
  bit  quiet_phase = 1'b0;     // no idling near the end
  bit  hold_sink = 1'b0;       // long receiver hold-off
  int unsigned watchdog = 0;

  function automatic void tokenizer_reset();
    p_mode = PM_VALUE; p_level = 0; p_accum = '0; p_neg = 1'b0;
    p_count = '0; p_err = ERR_OK; p_done = 1'b0;
    foreach (p_stack[k]) p_stack[k] = LV_NONE;
  endfunction

  function automatic void finish_value(bit was_key);
    if (p_level == 0) begin
      p_done = 1'b1; p_mode = PM_DONE;
    end else if (p_stack[p_level-1] == LV_LIST) begin
      p_mode = PM_VALUE;
    end else if (was_key) begin
      p_stack[p_level-1] = LV_DVAL; p_mode = PM_VALUE;
    end else begin
      p_stack[p_level-1] = LV_DKEY; p_mode = PM_KEY;
    end
  endfunction

  // Predict the tokenizer output for one accepted input beat.
  function automatic out_beat_t tokenize_byte(in_beat_t ib);
    out_beat_t   r;
    logic [7:0]  b;
    logic [63:0] d, lim, len_max;
    bit          isdig, k;
    b = ib.data_byte;
    d = 64'(b - ChZero);
    isdig = (b >= ChZero) && (b <= 8'h39);
    len_max = (LenWidth >= 64) ? '1 : ((64'd1 << LenWidth) - 1);
    r = '0;
    if (ib.restart) tokenizer_reset();
    if (p_err == ERR_OK && p_mode != PM_DONE) begin
      case (p_mode)
        PM_VALUE, PM_KEY: begin
          if (b == ChE && p_level > 0 &&
              (p_mode == PM_KEY || p_stack[p_level-1] == LV_LIST)) begin
            p_level--; r.event_res = EV_CLOSE; finish_value(1'b0);
          end else if (isdig) begin
            p_accum = d;
            p_mode = (p_mode == PM_KEY) ? PM_LEN_KEY : PM_LEN_VAL;
          end else if (p_mode == PM_KEY) begin
            p_err = ERR_KEY_NOT_STR;
          end else if (b == ChD || b == ChL) begin
            if (p_level >= Depth) p_err = ERR_TOO_DEEP;
            else begin
              p_stack[p_level] = (b == ChD) ? LV_DKEY : LV_LIST;
              p_level++;
              p_mode = (b == ChD) ? PM_KEY : PM_VALUE;
              r.event_res = (b == ChD) ? EV_DOPEN : EV_LOPEN;
            end
          end else if (b == ChI) begin
            p_accum = '0; p_neg = 1'b0; p_mode = PM_INT_START;
          end else p_err = ERR_BAD_START;
        end
        PM_INT_START, PM_INT_NEG, PM_INT_DIG: begin
          if (isdig) begin
            lim = p_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (p_accum > (lim - d) / 10) p_err = ERR_OVERFLOW;
            else begin
              p_accum = p_accum * 10 + d; p_mode = PM_INT_DIG;
            end
          end else if (p_mode == PM_INT_START && b == ChMinus) begin
            p_neg = 1'b1; p_mode = PM_INT_NEG;
          end else if (p_mode != PM_INT_DIG) begin
            p_err = ERR_NO_DIGITS;
          end else if (b == ChE) begin
            r.event_res = EV_INT;
            r.value = p_neg ? (64'd0 - p_accum) : p_accum;
            finish_value(1'b0);
          end else p_err = ERR_WRONG_CHAR;
        end
        PM_LEN_VAL, PM_LEN_KEY: begin
          k = (p_mode == PM_LEN_KEY);
          if (isdig) begin
            if (p_accum > (len_max - d) / 10) p_err = ERR_OVERFLOW;
            else p_accum = p_accum * 10 + d;
          end else if (b == ChColon) begin
            r.event_res = EV_SSTART; r.value = p_accum; r.is_key = k;
            p_count = p_accum;
            if (p_count == 0) finish_value(k);
            else p_mode = k ? PM_STR_KEY : PM_STR_VAL;
          end else p_err = ERR_WRONG_CHAR;
        end
        default: begin
          k = (p_mode == PM_STR_KEY);
          r.event_res = EV_SBYTE; r.value = 64'(b); r.is_key = k;
          p_count--;
          if (p_count == 0) finish_value(k);
        end
      endcase
      if (p_err != ERR_OK) begin
        r.event_res = EV_NONE; r.value = '0; r.is_key = 1'b0;
      end else if (ib.last_byte && !p_done) begin
        p_err = ((p_mode == PM_STR_VAL || p_mode == PM_STR_KEY) && p_count != 0)
                ? ERR_STR_CUT : ERR_EARLY_END;
      end
    end
    r.doc_done = p_done;
    r.error = p_err;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH at beat %0d: %s got %0h want %0h", beats_out, what, got, want);
    fail_count++;
  endtask

  // --- stimulus building ---------------------------------------------------
  function automatic void push_byte(logic [7:0] b, bit rs = 1'b0, bit lb = 1'b0);
    in_beat_t ib;
    ib.data_byte = b; ib.last_byte = lb; ib.restart = rs;
    pending_beats = {pending_beats, ib};
  endfunction

  function automatic void push_text(string s, bit rs = 1'b1);
    for (int k = 0; k < s.len(); k++) push_byte(s[k], rs && k == 0);
  endfunction

  function automatic string random_int_text();
    string s;
    logic [63:0] m;
    case ($urandom_range(0, 5))
      0: m = $urandom_range(0, 9);
      1: m = {$urandom, $urandom} >> $urandom_range(1, 63);
      2: m = 64'h7fff_ffff_ffff_ffff;
      3: m = 64'h8000_0000_0000_0000;
      default: m = $urandom_range(0, 100000);
    endcase
    if (m[63] && m != 64'h8000_0000_0000_0000) m[63] = 1'b0;
    if (m == 64'h8000_0000_0000_0000) s = $sformatf("i-%0de", m);
    else s = $sformatf("i%s%0de", ($urandom_range(0, 1) ? "-" : ""), m);
    return s;
  endfunction

  function automatic string random_str_text();
    string s;
    int n;
    n = $urandom_range(0, 5);
    s = $sformatf("%0d:", n);
    for (int k = 0; k < n; k++) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  function automatic string random_value(int lvl);
    string s;
    int n;
    int pick;
    pick = (lvl > 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    case (pick)
      0: s = random_int_text();
      1: s = random_str_text();
      2: begin
        s = "l";
        n = $urandom_range(0, 3);
        repeat (n) s = {s, random_value(lvl + 1)};
        s = {s, "e"};
      end
      default: begin
        s = "d";
        n = $urandom_range(0, 3);
        repeat (n) s = {s, random_str_text(), random_value(lvl + 1)};
        s = {s, "e"};
      end
    endcase
    return s;
  endfunction

  // Random document, sometimes corrupted, cut short, or with trailing noise.
  function automatic void push_random_doc();
    string s;
    int cut;
    s = random_value(0);
    case ($urandom_range(0, 9))
      0: s[$urandom_range(0, s.len()-1)] = 8'($urandom_range(0, 255));
      1: s = s.substr(0, $urandom_range(0, s.len()-1));
      default: ;
    endcase
    cut = s.len();
    for (int k = 0; k < cut; k++)
      push_byte(s[k], k == 0, (k == cut-1) && 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endfunction

  // --- driver: falling edge ------------------------------------------------
  int unsigned src_gap = 0;
  bit accepted_last = 1'b0;
  bit src_pause = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_last) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1; in_valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
          src_gap <= $urandom_range(0, 9); in_valid <= 1'b0;
        end else if (pending_beats.size() > 0 && !src_pause) begin
          in_data <= pending_beats.pop_front(); in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // acceptance seen at the rising edge; predictor runs here
  out_beat_t got, want;
  always @(posedge clk) begin
    accepted_last <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      watchdog <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : watchdog + 1;
      if (in_valid && !in_stall) begin
        expected_beats = {expected_beats, tokenize_byte(in_data)};
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        beats_out++;
        if (expected_beats.size() == 0) begin
          $display("UNEXPECTED output beat %0d", beats_out); fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got.event_res !== want.event_res) report_mismatch("event", got.event_res, want.event_res);
          if (got.value !== want.value)         report_mismatch("value", got.value, want.value);
          if (got.is_key !== want.is_key)       report_mismatch("is_key", got.is_key, want.is_key);
          if (got.doc_done !== want.doc_done)   report_mismatch("doc_done", got.doc_done, want.doc_done);
          if (got.error !== want.error)         report_mismatch("error", got.error, want.error);
        end
      end
    end
  end

  // --- receiver stall: falling edge ----------------------------------------
  int unsigned sink_gap = 0;
  int unsigned hold_count = 0;
  always @(negedge clk) begin
    if (hold_sink) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1; out_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 12) == 0) begin
      sink_gap <= $urandom_range(0, 9); out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if (watchdog >= WatchdogLimit && !hold_sink) begin
      $display("bencode_stream_tokenizer test failed");
      $finish;
    end
  end

  initial begin
    string deep;
    tokenizer_reset();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: events, extremes and each grammar fault
    push_text("d3:keyli-42ei0e4:spame1:ai9223372036854775807ee");
    push_text("i-9223372036854775808e");
    push_text("i9223372036854775808e");        // overflow
    push_text("i-9223372036854775809e");       // overflow negative
    push_text("i007e"); push_text("i-0e");
    push_text("ie"); push_text("i-e"); push_text("i1xe");
    push_text("0:"); push_text("4294967295:"); push_text("4294967296:");
    push_text("3x"); push_text("e"); push_text("x"); push_text("di1ei2ee");
    push_text("de"); push_text("d1:ae"); push_text("le");
    push_text("l1:a"); push_byte("e", 1'b0, 1'b1);
    push_text("3:a"); push_byte("b", 1'b0, 1'b1);   // string cut
    push_text("i5e"); push_byte(8'hff); push_byte(8'h00, 1'b0, 1'b1);
    deep = "";
    for (int k = 0; k < Depth; k++) deep = {deep, "l"};
    push_text({deep, "l"});                    // too deep
    push_text({deep, "i1e"});
    for (int k = 0; k < Depth; k++) push_byte("e");
    push_byte(8'h80, 1'b1, 1'b1);

    // first random part
    while (pending_beats.size() < 450) push_random_doc();
    wait (pending_beats.size() == 0);

    // receiver holds off long while the sender keeps offering
    push_text("l1:abcdefghijklmnopi1ei2ei3ee");
    while (pending_beats.size() < 90) push_random_doc();
    @(negedge clk) hold_sink = 1'b1;
    wait (hold_count >= 200);
    @(negedge clk) hold_sink = 1'b0;
    wait (pending_beats.size() == 0);

    // sender pauses until everything has drained
    src_pause = 1'b1;
    wait (expected_beats.size() == 0);
    @(negedge clk) src_pause = 1'b0;

    while (pending_beats.size() < 200) push_random_doc();
    wait (pending_beats.size() < 60);
    quiet_phase = 1'b1;
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_beats.size() == 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d input beats / %0d output beats: nested lists and dicts,",
             beats_in, beats_out);
    $display("integer and length extremes, every fault code, restarts and idling.");
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("bencode_stream_tokenizer test passed");
    end else begin
      $display("bencode_stream_tokenizer test failed");
    end
    $finish;
  end

endmodule
